// File: design/mandelbrot_escape_time_pixel_top_assert.svh
// assertion macros shared by the mandelbrot escape time pixel block
// no dependencies; included by the modules that carry assertions
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define MBET_ASSERT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define MBET_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mbet_pkg.sv
// shared types, constants and helper functions of the mandelbrot escape time block
// no dependencies
package mbet_pkg;

  localparam int FRAC_BITS = 28;
  localparam int MAX_SIDE  = 1024;

  localparam int Q_W     = FRAC_BITS + 4;
  localparam int P_W     = 2 * Q_W;
  localparam int IDX_W   = 10;
  localparam int DIV_W   = 11;
  localparam int LIM_W   = 8;
  localparam int COL_W   = 8;
  localparam int IDX3_W  = IDX_W + 2;
  localparam int NUM_W   = IDX3_W + FRAC_BITS;
  localparam int CFG_IDX_W = 2;

  localparam int CRD_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT   = 2'd2;

  localparam logic [DIV_W-1:0] IMAGE_WIDTH_RST  = 11'd256;
  localparam logic [DIV_W-1:0] IMAGE_HEIGHT_RST = 11'd256;
  localparam logic [LIM_W-1:0] ITER_LIMIT_RST   = 8'd100;

  localparam logic [COL_W-1:0] SCALE_SECOND = 8'd127;
  localparam logic [COL_W-1:0] SCALE_THIRD  = 8'd63;

  localparam logic signed [P_W-1:0] Q_MAX_P = {{(P_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic signed [P_W-1:0] Q_MIN_P = {{(P_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};
  localparam logic signed [P_W-1:0] HALF3_P = P_W'(3) << (FRAC_BITS - 1);
  localparam logic [P_W-1:0]        BOUND   = P_W'(4) << (2 * FRAC_BITS);

  typedef struct packed {
    logic [DIV_W-1:0] image_width;
    logic [DIV_W-1:0] image_height;
    logic [LIM_W-1:0] iteration_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [Q_W-1:0] cr;
    logic signed [Q_W-1:0] ci;
  } coord_t;

  typedef struct packed {
    logic [COL_W-1:0] color_first;
    logic [COL_W-1:0] color_second;
    logic [COL_W-1:0] color_third;
    logic             inside_set;
  } result_t;

  function automatic logic [DIV_W-1:0] eff_divisor(input logic [DIV_W-1:0] d);
    logic [DIV_W-1:0] r;
    r = d;
    if (d == '0) r = DIV_W'(1);
    else if (d > DIV_W'(MAX_SIDE)) r = DIV_W'(MAX_SIDE);
    return r;
  endfunction

  function automatic logic signed [P_W-1:0] sext_q(input logic signed [Q_W-1:0] q);
    return {{(P_W-Q_W){q[Q_W-1]}}, q};
  endfunction

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [P_W-1:0] x);
    logic signed [P_W-1:0] r;
    r = x;
    if (x > Q_MAX_P) r = Q_MAX_P;
    else if (x < Q_MIN_P) r = Q_MIN_P;
    return $signed(r[Q_W-1:0]);
  endfunction

  // n*mult/255 truncated, via (x + x/256 + 1)/256
  function automatic logic [COL_W-1:0] color_scale(input logic [COL_W-1:0] n,
                                                   input logic [COL_W-1:0] mult);
    logic [2*COL_W-1:0] x;
    logic [2*COL_W-1:0] s;
    x = {{COL_W{1'b0}}, n} * {{COL_W{1'b0}}, mult};
    s = x + (x >> COL_W) + (2*COL_W)'(1);
    return s[2*COL_W-1:COL_W];
  endfunction

endpackage

// File: design/mbet_fifo.sv
// small first-in first-out queue built from registers
// depends on mandelbrot_escape_time_pixel_top_assert.svh; DEPTH must be 2 or more
`include "mandelbrot_escape_time_pixel_top_assert.svh"

module mbet_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             wr_ok, rd_ok;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign wr_ok   = wr_en && !full;
  assign rd_ok   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_ok && !rd_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_ok && !wr_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `MBET_ASSERT(a_fifo_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH), "fifo overfilled")
  `MBET_ASSERT_NEXT(a_fifo_fill, clk, rst_n, wr_ok && !rd_ok, count_r == $past(count_r) + 1'b1, "fifo count lost a beat")

endmodule

// File: design/mbet_front.sv
// front end: takes a pixel beat and maps row and column to a Q4.28 point
// depends on mbet_pkg; one restoring divider shared by both coordinates
module mbet_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mbet_pkg::cfg_t               cfg,
  input  logic                         in_push,
  input  logic [mbet_pkg::IDX_W-1:0]   in_pixel_row,
  input  logic [mbet_pkg::IDX_W-1:0]   in_pixel_col,
  output logic                         in_full,
  output logic                         crd_push,
  output mbet_pkg::coord_t             crd_data,
  input  logic                         crd_full
);

  localparam int NUM_W = mbet_pkg::NUM_W;
  localparam int DIV_W = mbet_pkg::DIV_W;
  localparam int IDX_W = mbet_pkg::IDX_W;
  localparam int IDX3_W = mbet_pkg::IDX3_W;
  localparam int Q_W = mbet_pkg::Q_W;
  localparam int P_W = mbet_pkg::P_W;
  localparam int CNT_W = $clog2(NUM_W);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DIV_RE = 2'd1;
  localparam logic [1:0] S_DIV_IM = 2'd2;
  localparam logic [1:0] S_PUSH   = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      bit_cnt_r, bit_cnt_nxt;
  logic [NUM_W-1:0]      num_r, num_nxt;
  logic [DIV_W-1:0]      rem_r, rem_nxt;
  logic [DIV_W-1:0]      div_r, div_nxt;
  logic [IDX_W-1:0]      col_r, col_nxt;
  logic signed [Q_W-1:0] cr_r, cr_nxt;
  logic signed [Q_W-1:0] ci_r, ci_nxt;

  logic [DIV_W:0]        trial;
  logic                  ge;
  logic [DIV_W-1:0]      rem_step;
  logic [NUM_W-1:0]      quot;
  logic signed [Q_W-1:0] coord_val;
  logic                  last_bit;
  logic [IDX3_W-1:0]     row3, col3;

  assign trial     = {rem_r, num_r[NUM_W-1]};
  assign ge        = (trial >= {1'b0, div_r});
  assign rem_step  = ge ? DIV_W'(trial - {1'b0, div_r}) : trial[DIV_W-1:0];
  assign quot      = {num_r[NUM_W-2:0], ge};
  assign coord_val = mbet_pkg::sat_q($signed({{(P_W-NUM_W){1'b0}}, quot}) -
                                     mbet_pkg::HALF3_P);
  assign last_bit  = (bit_cnt_r == CNT_W'(NUM_W - 1));
  assign row3      = ({2'b00, in_pixel_row} << 1) + {2'b00, in_pixel_row};
  assign col3      = ({2'b00, col_r} << 1) + {2'b00, col_r};

  assign in_full  = (state_r != S_IDLE);
  assign crd_push = (state_r == S_PUSH);
  assign crd_data = '{cr: cr_r, ci: ci_r};

  always_comb begin
    state_nxt   = state_r;
    bit_cnt_nxt = bit_cnt_r;
    num_nxt     = num_r;
    rem_nxt     = rem_r;
    div_nxt     = div_r;
    col_nxt     = col_r;
    cr_nxt      = cr_r;
    ci_nxt      = ci_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_push) begin
          num_nxt     = {row3, {(NUM_W-IDX3_W){1'b0}}};
          rem_nxt     = '0;
          div_nxt     = mbet_pkg::eff_divisor(cfg.image_width);
          col_nxt     = in_pixel_col;
          bit_cnt_nxt = '0;
          state_nxt   = S_DIV_RE;
        end
      end
      S_DIV_RE, S_DIV_IM: begin
        num_nxt     = quot;
        rem_nxt     = rem_step;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (last_bit) begin
          bit_cnt_nxt = '0;
          if (state_r == S_DIV_RE) begin
            cr_nxt    = coord_val;
            num_nxt   = {col3, {(NUM_W-IDX3_W){1'b0}}};
            rem_nxt   = '0;
            div_nxt   = mbet_pkg::eff_divisor(cfg.image_height);
            state_nxt = S_DIV_IM;
          end else begin
            ci_nxt    = coord_val;
            state_nxt = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        if (!crd_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      bit_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    col_r <= col_nxt;
    cr_r  <= cr_nxt;
    ci_r  <= ci_nxt;
  end

endmodule

// File: design/mbet_back.sv
// back end: iterates z = z*z + c on one point and forms the colour beat
// depends on mbet_pkg and mandelbrot_escape_time_pixel_top_assert.svh
`include "mandelbrot_escape_time_pixel_top_assert.svh"

module mbet_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mbet_pkg::cfg_t    cfg,
  input  logic              crd_empty,
  input  mbet_pkg::coord_t  crd_data,
  output logic              crd_pop,
  input  logic              res_full,
  output logic              res_push,
  output mbet_pkg::result_t res_data
);

  localparam int Q_W   = mbet_pkg::Q_W;
  localparam int P_W   = mbet_pkg::P_W;
  localparam int LIM_W = mbet_pkg::LIM_W;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_ITER = 2'd1;
  localparam logic [1:0] B_MUL  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [LIM_W-1:0]      n_r, n_nxt;
  logic signed [Q_W-1:0] cr_r, cr_nxt;
  logic signed [Q_W-1:0] ci_r, ci_nxt;
  logic signed [Q_W-1:0] zr_r, zr_nxt;
  logic signed [Q_W-1:0] zi_r, zi_nxt;
  logic signed [P_W-1:0] rr_r, rr_nxt;
  logic signed [P_W-1:0] ii_r, ii_nxt;
  logic signed [P_W-1:0] ri_r, ri_nxt;

  logic [P_W-1:0]        mag;
  logic                  escaped;
  logic                  at_limit;
  logic signed [P_W-1:0] diff;
  logic signed [Q_W-1:0] nr, ni;
  logic                  busy, n_ok, inside_beat, black_beat;

  assign mag      = $unsigned(rr_r) + $unsigned(ii_r);
  assign escaped  = (mag > mbet_pkg::BOUND);
  assign at_limit = (n_r == cfg.iteration_limit);
  assign diff     = rr_r - ii_r;
  assign nr = mbet_pkg::sat_q((diff >>> mbet_pkg::FRAC_BITS) + mbet_pkg::sext_q(cr_r));
  assign ni = mbet_pkg::sat_q((ri_r >>> (mbet_pkg::FRAC_BITS - 1)) + mbet_pkg::sext_q(ci_r));

  assign crd_pop = (state_r == B_IDLE) && !crd_empty && !res_full;

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    cr_nxt    = cr_r;
    ci_nxt    = ci_r;
    zr_nxt    = zr_r;
    zi_nxt    = zi_r;
    rr_nxt    = rr_r;
    ii_nxt    = ii_r;
    ri_nxt    = ri_r;
    res_push  = 1'b0;
    res_data  = '{color_first: '0, color_second: '0, color_third: '0, inside_set: 1'b0};
    unique case (state_r)
      B_IDLE: begin
        if (crd_pop) begin
          cr_nxt    = crd_data.cr;
          ci_nxt    = crd_data.ci;
          zr_nxt    = '0;
          zi_nxt    = '0;
          rr_nxt    = '0;
          ii_nxt    = '0;
          ri_nxt    = '0;
          n_nxt     = '0;
          state_nxt = B_ITER;
        end
      end
      B_ITER: begin
        priority if (escaped) begin
          res_push              = 1'b1;
          res_data.color_first  = n_r;
          res_data.color_second = mbet_pkg::color_scale(n_r, mbet_pkg::SCALE_SECOND);
          res_data.color_third  = mbet_pkg::color_scale(n_r, mbet_pkg::SCALE_THIRD);
          state_nxt             = B_IDLE;
        end else if (at_limit) begin
          res_push            = 1'b1;
          res_data.inside_set = 1'b1;
          state_nxt           = B_IDLE;
        end else begin
          zr_nxt    = nr;
          zi_nxt    = ni;
          n_nxt     = n_r + 1'b1;
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        rr_nxt    = mbet_pkg::sext_q(zr_r) * mbet_pkg::sext_q(zr_r);
        ii_nxt    = mbet_pkg::sext_q(zi_r) * mbet_pkg::sext_q(zi_r);
        ri_nxt    = mbet_pkg::sext_q(zr_r) * mbet_pkg::sext_q(zi_r);
        state_nxt = B_ITER;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cr_r <= cr_nxt;
    ci_r <= ci_nxt;
    zr_r <= zr_nxt;
    zi_r <= zi_nxt;
    rr_r <= rr_nxt;
    ii_r <= ii_nxt;
    ri_r <= ri_nxt;
  end

  assign busy        = (state_r != B_IDLE);
  assign n_ok        = (n_r <= cfg.iteration_limit);
  assign inside_beat = res_push && res_data.inside_set;
  assign black_beat  = (res_data.color_first == '0) && (res_data.color_second == '0) &&
                       (res_data.color_third == '0);

  `MBET_ASSERT(a_push_room, clk, rst_n, res_push, !res_full, "result beat with no room")
  `MBET_ASSERT(a_count_limit, clk, rst_n, busy, n_ok, "iteration count past limit")
  `MBET_ASSERT(a_inside_black, clk, rst_n, inside_beat, black_beat, "inside pixel not black")

endmodule

// File: design/mandelbrot_escape_time_pixel_top.sv
// mandelbrot escape time pixel colouring, top level with configuration registers
// depends on mbet_pkg, mbet_fifo, mbet_front and mbet_back
// An accepted pixel is mapped to c = (3*row/width - 1.5) + i*(3*col/height - 1.5) in
// signed Q4.28 by the front end, whose one-bit-per-cycle restoring divider works out
// both coordinates before it takes the next pixel. The back end iterates z = z*z + c
// with three 32x32 multipliers, squaring z in B_MUL and updating it in B_ITER.
// A queue of CRD_DEPTH points sits between the two, so the sustained rate is the slower
// of the two per pixel; results leave through a queue of OUT_DEPTH beats.
module mandelbrot_escape_time_pixel_top #(
  parameter int CRD_DEPTH = mbet_pkg::CRD_DEPTH_DEF,
  parameter int OUT_DEPTH = mbet_pkg::OUT_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbet_pkg::DIV_W-1:0]       cfg_data,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [mbet_pkg::IDX_W-1:0]       in_pixel_row,
  input  logic [mbet_pkg::IDX_W-1:0]       in_pixel_col,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [mbet_pkg::COL_W-1:0]       out_color_first,
  output logic [mbet_pkg::COL_W-1:0]       out_color_second,
  output logic [mbet_pkg::COL_W-1:0]       out_color_third,
  output logic                             out_inside_set
);

  localparam int CRD_W = $bits(mbet_pkg::coord_t);
  localparam int RES_W = $bits(mbet_pkg::result_t);

  mbet_pkg::cfg_t    cfg_r, cfg_nxt;
  logic              crd_push, crd_full, crd_pop, crd_empty;
  mbet_pkg::coord_t  crd_wr, crd_rd;
  logic              res_push, res_full;
  mbet_pkg::result_t res_wr, res_rd;
  logic [CRD_W-1:0]  crd_rd_bits;
  logic [RES_W-1:0]  res_rd_bits;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mbet_pkg::REG_IMAGE_WIDTH:  cfg_nxt.image_width     = cfg_data;
        mbet_pkg::REG_IMAGE_HEIGHT: cfg_nxt.image_height    = cfg_data;
        mbet_pkg::REG_ITER_LIMIT:   cfg_nxt.iteration_limit = cfg_data[mbet_pkg::LIM_W-1:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{image_width:     mbet_pkg::IMAGE_WIDTH_RST,
                 image_height:    mbet_pkg::IMAGE_HEIGHT_RST,
                 iteration_limit: mbet_pkg::ITER_LIMIT_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mbet_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_push      (in_push),
    .in_pixel_row (in_pixel_row),
    .in_pixel_col (in_pixel_col),
    .in_full      (in_full),
    .crd_push     (crd_push),
    .crd_data     (crd_wr),
    .crd_full     (crd_full)
  );

  mbet_fifo #(
    .WIDTH (CRD_W),
    .DEPTH (CRD_DEPTH)
  ) u_crd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (crd_push),
    .wr_data (crd_wr),
    .full    (crd_full),
    .rd_en   (crd_pop),
    .rd_data (crd_rd_bits),
    .empty   (crd_empty)
  );

  assign crd_rd = mbet_pkg::coord_t'(crd_rd_bits);

  mbet_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .crd_empty (crd_empty),
    .crd_data  (crd_rd),
    .crd_pop   (crd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_wr)
  );

  mbet_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (res_rd_bits),
    .empty   (out_empty)
  );

  assign res_rd           = mbet_pkg::result_t'(res_rd_bits);
  assign out_color_first  = res_rd.color_first;
  assign out_color_second = res_rd.color_second;
  assign out_color_third  = res_rd.color_third;
  assign out_inside_set   = res_rd.inside_set;

endmodule

// File: verif/testbench.sv
// testbench for mandelbrot_escape_time_pixel_top: escape-time colors of single pixels
// predicts every color beat in Q4.28 fixed point and checks it; depends on mbet_pkg
`timescale 1ns / 100ps

module testbench;
  import mbet_pkg::*;

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic signed [P_W-1:0] wide_t;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam wide_t Q_TOP = (wide_t'(1) <<< (Q_W - 1)) - 1;
  localparam wide_t Q_BOTTOM = -(wide_t'(1) <<< (Q_W - 1));
  localparam logic [P_W-1:0] ESCAPE_BOUND = 64'd4 << (2 * FRAC_BITS);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIV_W-1:0] cfg_data = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic [IDX_W-1:0] in_pixel_row = '0;
  logic [IDX_W-1:0] in_pixel_col = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [COL_W-1:0] out_color_first;
  logic [COL_W-1:0] out_color_second;
  logic [COL_W-1:0] out_color_third;
  logic out_inside_set;

  cfg_t cur_cfg = '{image_width: IMAGE_WIDTH_RST, image_height: IMAGE_HEIGHT_RST,
                    iteration_limit: ITER_LIMIT_RST};
  result_t pending_colors[$];
  bit feed_gaps = 1'b1;
  bit drain_stalls = 1'b1;
  int hold_cycles = 0;
  int error_count = 0;
  int pixels_sent = 0;
  int beats_seen = 0;
  int inside_seen = 0;
  int deepest_escape = 0;
  int settings_used = 1;
  int full_waits = 0;

  mandelbrot_escape_time_pixel_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full),
    .in_pixel_row(in_pixel_row), .in_pixel_col(in_pixel_col),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_color_first(out_color_first), .out_color_second(out_color_second),
    .out_color_third(out_color_third), .out_inside_set(out_inside_set)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic q_t clamp_q(input wide_t x);
    if (x > Q_TOP) return q_t'(Q_TOP);
    if (x < Q_BOTTOM) return q_t'(Q_BOTTOM);
    return q_t'(x);
  endfunction

  // 3*idx/side - 1.5, side forced into 1..MAX_SIDE
  function automatic q_t map_coord(input logic [IDX_W-1:0] idx, input logic [DIV_W-1:0] side);
    logic [DIV_W-1:0] div;
    wide_t quot;
    div = side;
    if (side == '0) div = 1;
    else if (side > MAX_SIDE) div = MAX_SIDE;
    quot = (wide_t'(3 * idx) <<< FRAC_BITS) / wide_t'(div);
    return clamp_q(quot - (wide_t'(3) <<< (FRAC_BITS - 1)));
  endfunction

  function automatic result_t predict_color(input logic [IDX_W-1:0] row,
                                            input logic [IDX_W-1:0] col);
    q_t cr, ci, zr, zi;
    wide_t rr, ii, ri;
    int unsigned n, count;
    result_t r;
    cr = map_coord(row, cur_cfg.image_width);
    ci = map_coord(col, cur_cfg.image_height);
    zr = '0;
    zi = '0;
    count = 0;
    for (n = 1; n <= cur_cfg.iteration_limit && count == 0; n++) begin
      rr = wide_t'(zr) * wide_t'(zr);
      ii = wide_t'(zi) * wide_t'(zi);
      ri = wide_t'(zr) * wide_t'(zi);
      zr = clamp_q(((rr - ii) >>> FRAC_BITS) + wide_t'(cr));
      zi = clamp_q((ri >>> (FRAC_BITS - 1)) + wide_t'(ci));
      rr = wide_t'(zr) * wide_t'(zr);
      ii = wide_t'(zi) * wide_t'(zi);
      if ($unsigned(rr) + $unsigned(ii) > ESCAPE_BOUND) count = n;
    end
    if (count > 0) begin
      r.color_first = COL_W'(count);
      r.color_second = COL_W'((count * 127) / 255);
      r.color_third = COL_W'((count * 63) / 255);
      r.inside_set = 1'b0;
    end else begin
      r = '0;
      r.inside_set = 1'b1;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      error_count++;
      if (error_count <= 10)
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : color_check
    result_t want;
    if (rst_n && out_pop && !out_empty) begin
      beats_seen++;
      if (pending_colors.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("%0t: color beat with nothing pending", $time);
      end else begin
        want = pending_colors.pop_front();
        check_field("color_first", want.color_first, out_color_first);
        check_field("color_second", want.color_second, out_color_second);
        check_field("color_third", want.color_third, out_color_third);
        check_field("inside_set", want.inside_set, out_inside_set);
        if (want.inside_set) inside_seen++;
        else if (want.color_first > deepest_escape) deepest_escape = want.color_first;
      end
    end
  end

  // pop side: random stalls per beat, plus a long hold-off on request
  initial begin : result_drain
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_pop <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = drain_stalls ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
    end
  end

  // push stays high after a beat so back-to-back pixels need no gap
  task automatic feed_pixel(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
    int gap;
    gap = feed_gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_pixel_row <= row;
    in_pixel_col <= col;
    @(posedge clk);
    while (in_full) begin
      full_waits++;
      @(posedge clk);
    end
    pending_colors.push_back(predict_color(row, col));
    pixels_sent++;
  endtask

  task automatic drain_to_idle();
    in_push <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIV_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH: cur_cfg.image_width = value;
      REG_IMAGE_HEIGHT: cur_cfg.image_height = value;
      REG_ITER_LIMIT: cur_cfg.iteration_limit = value[LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [DIV_W-1:0] w, input logic [DIV_W-1:0] h,
                                input logic [DIV_W-1:0] lim);
    drain_to_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_ITER_LIMIT, lim);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [DIV_W-1:0] draw_side();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DIV_W'($urandom_range(MAX_SIDE + 1, 2047));
      2: return DIV_W'(MAX_SIDE);
      3: return DIV_W'($urandom_range(1, 4));
      default: return DIV_W'($urandom_range(5, MAX_SIDE - 1));
    endcase
  endfunction

  // mostly inside the image, sometimes anywhere in the index range
  function automatic logic [IDX_W-1:0] draw_index(input logic [DIV_W-1:0] side);
    int span;
    span = (side == '0) ? 1 : (side > MAX_SIDE) ? MAX_SIDE : side;
    if ($urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, 1023));
    return IDX_W'($urandom_range(0, span - 1));
  endfunction

  task automatic test_reset_settings();
    feed_pixel(10'd0, 10'd0);
    feed_pixel(10'd1023, 10'd1023);
    feed_pixel(10'd128, 10'd128);
    feed_pixel(10'd64, 10'd128);
    feed_pixel(10'd170, 10'd128);
    feed_pixel(10'd0, 10'd1023);
    feed_pixel(10'd1023, 10'd0);
    feed_pixel(10'd85, 10'd213);
  endtask

  task automatic test_divisor_limits();
    apply_settings(11'd0, 11'h7FF, 11'd100);
    feed_pixel(10'd0, 10'd0);
    feed_pixel(10'd1, 10'd512);
    feed_pixel(10'd0, 10'd1023);
    feed_pixel(10'd0, 10'd600);
    apply_settings(11'd1024, 11'd1, 11'd255);
    feed_pixel(10'd512, 10'd0);
    feed_pixel(10'd1023, 10'd0);
    feed_pixel(10'd300, 10'd1);
  endtask

  task automatic test_iteration_limits();
    apply_settings(11'd256, 11'd256, 11'd0);
    feed_pixel(10'd128, 10'd128);
    feed_pixel(10'd0, 10'd0);
    drain_to_idle();
    // unmapped index must not disturb the real registers
    write_reg(REG_UNMAPPED, 11'h7FF);
    write_reg(REG_ITER_LIMIT, 11'h7FF);
    cfg_we <= 1'b0;
    feed_pixel(10'd128, 10'd128);
    feed_pixel(10'd0, 10'd128);
    feed_pixel(10'd90, 10'd90);
    drain_to_idle();
    write_reg(REG_ITER_LIMIT, 11'd1);
    cfg_we <= 1'b0;
    feed_pixel(10'd0, 10'd0);
    feed_pixel(10'd128, 10'd128);
  endtask

  task automatic test_output_backpressure();
    int k;
    apply_settings(11'd256, 11'd256, 11'd100);
    feed_gaps = 1'b0;
    hold_cycles = 2500;
    for (k = 0; k < 16; k++) feed_pixel(draw_index(11'd256), draw_index(11'd256));
    drain_to_idle();
    feed_gaps = 1'b1;
  endtask

  task automatic test_random_images();
    logic [DIV_W-1:0] w, h, lim;
    int phase, k;
    for (phase = 0; phase < 8; phase++) begin
      w = draw_side();
      h = draw_side();
      case ($urandom_range(0, 5))
        0: lim = 11'd255;
        1: lim = 11'd1;
        default: lim = DIV_W'($urandom_range(2, 80));
      endcase
      apply_settings(w, h, lim);
      feed_gaps = (phase % 3) != 2;
      drain_stalls = (phase % 4) != 3;
      for (k = 0; k < 125; k++) feed_pixel(draw_index(w), draw_index(h));
    end
    feed_gaps = 1'b1;
    drain_stalls = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_settings();
    test_divisor_limits();
    test_iteration_limits();
    test_output_backpressure();
    test_random_images();
    drain_to_idle();
    repeat (40) @(posedge clk);
    error_count += pending_colors.size();
    $display("sent %0d pixels under %0d register settings, %0d color beats checked",
             pixels_sent, settings_used, beats_seen);
    $display("%0d inside, deepest escape %0d, %0d cycles with input stalled, %0d errors",
             inside_seen, deepest_escape, full_waits, error_count);
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("timeout with %0d color beats pending", pending_colors.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
